>>> rtl/skt_pkg.sv
// constants, types and codes shared by the sorted key table
package skt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int PAY_W       = 32;
	localparam int REQ_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 7;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE,
		S_SHUP,
		S_SHDN,
		S_PLACE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic        [PAY_W-1:0] payload;
	} entry_t;

endpackage

>>> rtl/skt_if.sv
// request and response channel interfaces of the sorted key table
interface skt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic        [skt_pkg::REQ_W-1:0]     req_type;
	logic signed [skt_pkg::KEY_W-1:0]     entry_key;
	logic        [skt_pkg::PAY_W-1:0]     entry_payload;

	modport source (output valid, req_type, entry_key, entry_payload, input ready);
	modport sink (input valid, req_type, entry_key, entry_payload, output ready);
endinterface

interface skt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [skt_pkg::STATUS_W-1:0]         status;
	logic [skt_pkg::PAY_W-1:0]            found_payload;
	logic [skt_pkg::COUNT_W-1:0]          entry_count;

	modport source (output valid, status, found_payload, entry_count, input ready);
	modport sink (input valid, status, found_payload, entry_count, output ready);
endinterface

>>> rtl/skt_store.sv
// entry store: one write port and one registered read port
module skt_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [skt_pkg::IDX_W-1:0]   wr_addr,
	input  skt_pkg::entry_t             wr_data,
	input  logic                        rd_en,
	input  logic [skt_pkg::IDX_W-1:0]   rd_addr,
	output skt_pkg::entry_t             rd_data
);

	skt_pkg::entry_t mem_q [skt_pkg::TABLE_DEPTH];
	skt_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/sorted_key_table.sv
// sorted key table: holds up to TABLE_DEPTH (key, payload) entries in ascending signed key
// order and serves insert, lookup and remove requests one at a time. a request scans the
// store from the bottom, one entry per cycle, until it reaches the first key not smaller
// than its own; an insert then moves every larger entry up and a remove moves every later
// entry down, again one entry per cycle, since the store has one read and one write port.
// the block goes back to idle, ready for the next word, as the result is registered. the
// response register lets a new request start while the previous result still waits to be
// taken. the store needs no clearing after reset: only entries below the count are read.
module sorted_key_table (
	input  logic         clk,
	input  logic         arst_n,
	skt_req_if.sink      req,
	skt_rsp_if.source    rsp
);

	localparam int CW = skt_pkg::CNT_W;
	localparam int IW = skt_pkg::IDX_W;

	skt_pkg::state_t                  state_q, state_d;
	logic [skt_pkg::REQ_W-1:0]        req_q, req_d;
	logic signed [skt_pkg::KEY_W-1:0] key_q, key_d;
	logic [skt_pkg::PAY_W-1:0]        pay_q, pay_d;
	logic [CW-1:0]                    count_q, count_d;
	logic [CW-1:0]                    idx_q, idx_d;
	logic [CW-1:0]                    pos_q, pos_d;
	logic [CW-1:0]                    j_q, j_d;
	logic                             hit_q, hit_d;
	logic [skt_pkg::PAY_W-1:0]        hitpay_q, hitpay_d;
	skt_pkg::status_t                 status_q, status_d;
	logic [skt_pkg::PAY_W-1:0]        found_q, found_d;

	logic                             out_valid_q;
	logic [skt_pkg::STATUS_W-1:0]     out_status_q;
	logic [skt_pkg::PAY_W-1:0]        out_found_q;
	logic [skt_pkg::COUNT_W-1:0]      out_count_q;
	logic                             load_out;

	logic                             rd_en, wr_en;
	logic [IW-1:0]                    rd_addr, wr_addr;
	skt_pkg::entry_t                  rd_data, wr_data;

	logic [CW-1:0]                    idx_inc, pos_inc, j_dec, j_dec2, j_inc, j_inc2, cnt_dec;

	assign idx_inc = idx_q + CW'(1);
	assign pos_inc = pos_q + CW'(1);
	assign j_dec   = j_q - CW'(1);
	assign j_dec2  = j_q - CW'(2);
	assign j_inc   = j_q + CW'(1);
	assign j_inc2  = j_q + CW'(2);
	assign cnt_dec = count_q - CW'(1);

	skt_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		key_d    = key_q;
		pay_d    = pay_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		j_d      = j_q;
		hit_d    = hit_q;
		hitpay_d = hitpay_q;
		status_d = status_q;
		found_d  = found_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_data;
		load_out = 1'b0;
		req.ready = (state_q == skt_pkg::S_IDLE);

		unique case (state_q)
			skt_pkg::S_IDLE: begin
				if (req.valid) begin
					req_d = req.req_type;
					key_d = req.entry_key;
					pay_d = req.entry_payload;
					idx_d = '0;
					if (count_q == '0) begin
						pos_d   = '0;
						hit_d   = 1'b0;
						state_d = skt_pkg::S_RESOLVE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = skt_pkg::S_SCAN;
					end
				end
			end
			skt_pkg::S_SCAN: begin
				if (rd_data.key >= key_q) begin
					pos_d    = idx_q;
					hit_d    = (rd_data.key == key_q);
					hitpay_d = rd_data.payload;
					state_d  = skt_pkg::S_RESOLVE;
				end else if (idx_inc == count_q) begin
					pos_d   = count_q;
					hit_d   = 1'b0;
					state_d = skt_pkg::S_RESOLVE;
				end else begin
					idx_d   = idx_inc;
					rd_en   = 1'b1;
					rd_addr = idx_inc[IW-1:0];
				end
			end
			skt_pkg::S_RESOLVE: begin
				status_d = skt_pkg::ST_NOT_FOUND;
				found_d  = '0;
				state_d  = skt_pkg::S_DONE;
				case (req_q)
					skt_pkg::REQ_INSERT: begin
						if (hit_q) begin
							status_d = skt_pkg::ST_DUPLICATE;
						end else if (count_q == CW'(skt_pkg::TABLE_DEPTH)) begin
							status_d = skt_pkg::ST_FULL;
						end else if (pos_q == count_q) begin
							state_d = skt_pkg::S_PLACE;
						end else begin
							j_d     = count_q;
							rd_en   = 1'b1;
							rd_addr = cnt_dec[IW-1:0];
							state_d = skt_pkg::S_SHUP;
						end
					end
					skt_pkg::REQ_LOOKUP: begin
						if (hit_q) begin
							status_d = skt_pkg::ST_FOUND;
							found_d  = hitpay_q;
						end
					end
					skt_pkg::REQ_REMOVE: begin
						if (hit_q) begin
							status_d = skt_pkg::ST_REMOVED;
							found_d  = hitpay_q;
							if (pos_inc == count_q) begin
								count_d = cnt_dec;
							end else begin
								j_d     = pos_q;
								rd_en   = 1'b1;
								rd_addr = pos_inc[IW-1:0];
								state_d = skt_pkg::S_SHDN;
							end
						end
					end
					default: begin
						status_d = skt_pkg::ST_NOT_FOUND;
					end
				endcase
			end
			skt_pkg::S_SHUP: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_data;
				j_d     = j_dec;
				if (j_dec == pos_q) begin
					state_d = skt_pkg::S_PLACE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = j_dec2[IW-1:0];
				end
			end
			skt_pkg::S_SHDN: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_data;
				j_d     = j_inc;
				if (j_inc2 == count_q) begin
					count_d = cnt_dec;
					state_d = skt_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = j_inc2[IW-1:0];
				end
			end
			skt_pkg::S_PLACE: begin
				wr_en    = 1'b1;
				wr_addr  = pos_q[IW-1:0];
				wr_data  = '{key: key_q, payload: pay_q};
				count_d  = count_q + CW'(1);
				status_d = skt_pkg::ST_INSERTED;
				found_d  = '0;
				state_d  = skt_pkg::S_DONE;
			end
			skt_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = skt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		key_q    <= key_d;
		pay_q    <= pay_d;
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		j_q      <= j_d;
		hit_q    <= hit_d;
		hitpay_q <= hitpay_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_count_q  <= skt_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.found_payload = out_found_q;
	assign rsp.entry_count   = out_count_q;

endmodule

>>> rtl/skt_checker.sv
// port-level checks of the sorted key table and their binding
module skt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [skt_pkg::STATUS_W-1:0]   rsp_status,
	input logic [skt_pkg::PAY_W-1:0]      rsp_found_payload,
	input logic [skt_pkg::COUNT_W-1:0]    rsp_entry_count
);

	// busy after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_payload) && $stable(rsp_entry_count))
		else $error("stalled response word changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= skt_pkg::COUNT_W'(skt_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !(rsp_status == skt_pkg::ST_FOUND || rsp_status == skt_pkg::ST_REMOVED)
			|-> rsp_found_payload == '0)
		else $error("payload set on a response without a matching entry");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_found_payload (rsp.found_payload),
	.rsp_entry_count   (rsp.entry_count)
);

>>> tb/tb.sv
// self-checking testbench for the sorted key table
module tb;
	import skt_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int KEY_MIN = 32'sh8000_0000;
	localparam int KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [REQ_W-1:0]        req_type;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		int                      gap;
		bit                      hold_for_idle;
	} table_req_t;

	typedef struct {
		status_t              status;
		logic [PAY_W-1:0]     found_payload;
		logic [COUNT_W-1:0]   entry_count;
	} table_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	skt_req_if req_ch();
	skt_rsp_if rsp_ch();

	sorted_key_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// table contents as the block should hold them
	logic signed [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	logic [PAY_W-1:0]        tbl_pay [TABLE_DEPTH];
	int                      held_n = 0;

	table_req_t pending_reqs[$];
	table_rsp_t expected_rsps[$];
	int         mismatches = 0;

	// keys held, as tracked while building the request list
	int gen_keys[$];
	bit gen_burst;
	bit gen_hold_next;

	logic req_fire;
	logic rsp_fire;
	int   gap_left = 0;
	int   rsp_stall = 0;
	bit   rsp_burst = 1'b0;

	function automatic table_rsp_t serve_request(logic [REQ_W-1:0] rt,
			logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		table_rsp_t r;
		int hit;
		int slot;
		r.status = ST_NOT_FOUND;
		r.found_payload = '0;
		hit = -1;
		slot = 0;
		for (int i = 0; i < held_n; i++) begin
			if (hit < 0 && tbl_key[i] == k)
				hit = i;
			if (k > tbl_key[i])
				slot = i + 1;
		end
		case (rt)
			REQ_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_DUPLICATE;
				end else if (held_n >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = held_n; i > slot; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_pay[i] = tbl_pay[i-1];
					end
					tbl_key[slot] = k;
					tbl_pay[slot] = p;
					held_n++;
					r.status = ST_INSERTED;
				end
			end
			REQ_LOOKUP: begin
				if (hit >= 0) begin
					r.status = ST_FOUND;
					r.found_payload = tbl_pay[hit];
				end
			end
			REQ_REMOVE: begin
				if (hit >= 0) begin
					r.found_payload = tbl_pay[hit];
					for (int i = hit; i < held_n - 1; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_pay[i] = tbl_pay[i+1];
					end
					held_n--;
					r.status = ST_REMOVED;
				end
			end
			default: ;
		endcase
		r.entry_count = COUNT_W'(held_n);
		return r;
	endfunction

	function automatic int gen_find(int k);
		foreach (gen_keys[i]) begin
			if (gen_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	function automatic int pick_key(bit want_held);
		int sel;
		sel = $urandom_range(0, 9);
		if (want_held && gen_keys.size() != 0)
			return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
		if (sel < 4)
			return $urandom;
		if (sel < 8)
			return $urandom_range(0, 60) - 30;
		case ($urandom_range(0, 5))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return KEY_MIN + 1;
			3: return KEY_MAX - 1;
			4: return -1;
			default: return 0;
		endcase
	endfunction

	function automatic int new_key();
		int k;
		do k = pick_key(1'b0); while (gen_find(k) >= 0);
		return k;
	endfunction

	function automatic void push_req(logic [REQ_W-1:0] rt, int k, logic [PAY_W-1:0] p);
		table_req_t w;
		int at;
		w.req_type = rt;
		w.key = k;
		w.payload = p;
		w.gap = gen_burst ? 0 : $urandom_range(0, 9);
		w.hold_for_idle = gen_hold_next;
		gen_hold_next = 1'b0;
		pending_reqs.push_back(w);
		at = gen_find(k);
		if (rt == REQ_INSERT && at < 0 && gen_keys.size() < TABLE_DEPTH)
			gen_keys.push_back(k);
		else if (rt == REQ_REMOVE && at >= 0)
			gen_keys.delete(at);
	endfunction

	always @(negedge clk) begin : req_drive
		table_req_t cur;
		if (arst_n) begin
			if (!req_ch.valid || req_fire) begin
				if (gap_left != 0) begin
					req_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() != 0 &&
						(!pending_reqs[0].hold_for_idle || expected_rsps.size() == 0)) begin
					cur = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= cur.req_type;
					req_ch.entry_key <= cur.key;
					req_ch.entry_payload <= cur.payload;
					gap_left <= (pending_reqs.size() != 0) ? pending_reqs[0].gap : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin : rsp_drive
		int n;
		if (arst_n) begin
			if (rsp_fire) begin
				if ($urandom_range(0, 59) == 0)
					rsp_burst = ~rsp_burst;
				n = rsp_burst ? 0 : $urandom_range(0, 9);
				rsp_stall <= n;
				rsp_ch.ready <= (n == 0);
			end else if (rsp_stall != 0) begin
				rsp_stall <= rsp_stall - 1;
				rsp_ch.ready <= (rsp_stall == 1);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		table_rsp_t want;
		if (!arst_n) begin
			req_fire <= 1'b0;
			rsp_fire <= 1'b0;
		end else begin
			req_fire <= req_ch.valid && req_ch.ready;
			rsp_fire <= rsp_ch.valid && rsp_ch.ready;
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(serve_request(req_ch.req_type, req_ch.entry_key,
					req_ch.entry_payload));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					$error("unexpected response word: status %0d", rsp_ch.status);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.status !== want.status) begin
						mismatches++;
						$error("status: expected %0d, got %0d", want.status,
							rsp_ch.status);
					end
					if (rsp_ch.found_payload !== want.found_payload) begin
						mismatches++;
						$error("found_payload: expected %h, got %h",
							want.found_payload, rsp_ch.found_payload);
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						mismatches++;
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp_ch.entry_count);
					end
				end
			end
		end
	end

	initial begin
		int roll;
		int phase;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.entry_key = '0;
		req_ch.entry_payload = '0;
		rsp_ch.ready = 1'b0;

		// empty table, unused code, extremes, duplicates, removes at both ends
		gen_burst = 1'b0;
		gen_hold_next = 1'b0;
		push_req(REQ_LOOKUP, 0, 32'h0);
		push_req(REQ_REMOVE, 5, 32'h0);
		push_req(REQ_UNUSED, 0, 32'hffff_ffff);
		push_req(REQ_INSERT, KEY_MIN, 32'h0000_0000);
		push_req(REQ_INSERT, KEY_MAX, 32'hffff_ffff);
		push_req(REQ_INSERT, 0, 32'ha5a5_a5a5);
		push_req(REQ_INSERT, -1, 32'h5a5a_5a5a);
		push_req(REQ_INSERT, 1, 32'h1234_5678);
		push_req(REQ_INSERT, KEY_MIN, 32'hdead_beef);
		push_req(REQ_LOOKUP, KEY_MIN, 32'hffff_ffff);
		push_req(REQ_LOOKUP, KEY_MAX, 32'h0);
		push_req(REQ_LOOKUP, -1, 32'h0);
		push_req(REQ_LOOKUP, 2, 32'h0);
		push_req(REQ_UNUSED, 0, 32'h0);
		push_req(REQ_REMOVE, 0, 32'h0);
		push_req(REQ_REMOVE, 0, 32'h0);
		push_req(REQ_LOOKUP, 1, 32'h0);
		push_req(REQ_REMOVE, KEY_MIN, 32'h0);
		push_req(REQ_REMOVE, KEY_MAX, 32'h0);
		push_req(REQ_INSERT, KEY_MIN + 1, 32'h8000_0001);
		push_req(REQ_LOOKUP, -2, 32'h0);
		push_req(REQ_REMOVE, -1, 32'h0);
		push_req(REQ_REMOVE, 1, 32'h0);
		push_req(REQ_REMOVE, KEY_MIN + 1, 32'h0);

		phase = 0;
		while (pending_reqs.size() < 1800) begin
			gen_burst = ($urandom_range(0, 3) == 0);
			gen_hold_next = 1'b1;
			case (phase % 3)
				0: begin
					// fill up to full, then hit duplicate and full on a full table
					while (gen_keys.size() < TABLE_DEPTH) begin
						roll = $urandom_range(0, 9);
						if (roll < 8)
							push_req(REQ_INSERT, new_key(), $urandom);
						else if (roll == 8)
							push_req(REQ_LOOKUP, pick_key($urandom_range(0, 1)), $urandom);
						else
							push_req(REQ_INSERT, pick_key(1'b1), $urandom);
					end
					push_req(REQ_INSERT, pick_key(1'b1), $urandom);
					push_req(REQ_INSERT, new_key(), $urandom);
					push_req(REQ_LOOKUP, pick_key(1'b1), $urandom);
					push_req(REQ_REMOVE, pick_key(1'b1), $urandom);
					push_req(REQ_INSERT, new_key(), $urandom);
					push_req(REQ_INSERT, new_key(), $urandom);
				end
				1: begin
					repeat (150) begin
						roll = $urandom_range(0, 19);
						if (roll < 8)
							push_req(REQ_INSERT, pick_key(roll < 2), $urandom);
						else if (roll < 14)
							push_req(REQ_LOOKUP, pick_key($urandom_range(0, 1)), $urandom);
						else if (roll < 19)
							push_req(REQ_REMOVE, pick_key($urandom_range(0, 1)), $urandom);
						else
							push_req(REQ_UNUSED, pick_key($urandom_range(0, 1)), $urandom);
					end
				end
				default: begin
					while (gen_keys.size() != 0) begin
						roll = $urandom_range(0, 9);
						if (roll < 7)
							push_req(REQ_REMOVE, pick_key(1'b1), $urandom);
						else if (roll == 7)
							push_req(REQ_LOOKUP, pick_key(1'b1), $urandom);
						else if (roll == 8)
							push_req(REQ_REMOVE, pick_key(1'b0), $urandom);
						else
							push_req(REQ_LOOKUP, pick_key(1'b0), $urandom);
					end
					push_req(REQ_LOOKUP, pick_key(1'b0), $urandom);
					push_req(REQ_REMOVE, pick_key(1'b0), $urandom);
				end
			endcase
			phase++;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (2 * TABLE_DEPTH + 10) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> sorted_key_table.f
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_store.sv
rtl/sorted_key_table.sv
rtl/skt_checker.sv
tb/tb.sv
